>>> src/cpid_pkg.sv
package cpid_pkg;

  localparam int W         = 32;
  localparam int FRAC_BITS = 16;
  localparam int LIM_W     = 31;
  localparam int PROD_W    = 2 * W;
  localparam int MAG_W     = PROD_W - 1;
  localparam int DIV_STEPS = MAG_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int IDX_W     = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_GAIN_PROP      = 3'd0,
    REG_GAIN_INTEGRAL  = 3'd1,
    REG_GAIN_DERIV     = 3'd2,
    REG_LIMIT_PROP     = 3'd3,
    REG_LIMIT_INTEGRAL = 3'd4,
    REG_LIMIT_DERIV    = 3'd5,
    REG_LIMIT_TOTAL    = 3'd6
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MP,
    S_MI,
    S_MD,
    S_MT,
    S_INC,
    S_ACC,
    S_DIV,
    S_SUM,
    S_OUT
  } state_t;

  localparam logic signed [W+1:0]     WMAX34 = 34'sh0_7FFF_FFFF;
  localparam logic signed [W+1:0]     WMIN34 = -34'sh0_8000_0000;
  localparam logic signed [PROD_W-1:0] WMAX64 = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [PROD_W-1:0] WMIN64 = -64'sh0000_0000_8000_0000;

  function automatic logic signed [W-1:0] sat_word(input logic signed [W+1:0] v);
    logic signed [W-1:0] r;
    if (v > WMAX34) begin
      r = WMAX34[W-1:0];
    end else if (v < WMIN34) begin
      r = WMIN34[W-1:0];
    end else begin
      r = v[W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [W-1:0] scale_sat(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] sh;
    logic signed [W-1:0]      r;
    sh = p >>> FRAC_BITS;
    if (sh > WMAX64) begin
      r = WMAX64[W-1:0];
    end else if (sh < WMIN64) begin
      r = WMIN64[W-1:0];
    end else begin
      r = sh[W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [W-1:0] clamp_sym(input logic signed [W+1:0] v,
                                                    input logic [LIM_W-1:0] lim);
    logic signed [W+1:0] lim_s;
    logic signed [W+1:0] r;
    lim_s = signed'({3'b000, lim});
    if (v > lim_s) begin
      r = lim_s;
    end else if (v < -lim_s) begin
      r = -lim_s;
    end else begin
      r = v;
    end
    return r[W-1:0];
  endfunction

  function automatic logic signed [W+1:0] ext(input logic signed [W-1:0] v);
    return {{2{v[W-1]}}, v};
  endfunction

endpackage

>>> src/cpid_mul.sv
module cpid_mul (
  input  logic                                  clk,
  input  logic signed [cpid_pkg::W-1:0]         a,
  input  logic signed [cpid_pkg::W-1:0]         b,
  output logic signed [cpid_pkg::PROD_W-1:0]    prod
);
  import cpid_pkg::*;

  always_ff @(posedge clk) begin
    prod <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

>>> src/cpid_div.sv
module cpid_div (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic signed [cpid_pkg::PROD_W-1:0]    dividend,
  input  logic        [cpid_pkg::LIM_W-1:0]     divisor,
  output logic                                  busy,
  output logic signed [cpid_pkg::W-1:0]         quotient
);
  import cpid_pkg::*;

  logic [MAG_W-1:0] work;
  logic [LIM_W-1:0] rem;
  logic [LIM_W-1:0] dsr;
  logic [CNT_W-1:0] cnt;
  logic             neg;
  logic [LIM_W:0]   trial;
  logic             qbit;
  logic [PROD_W-1:0] mag;

  assign mag   = dividend[PROD_W-1] ? PROD_W'(-dividend) : PROD_W'(dividend);
  assign trial = {rem, work[MAG_W-1]};
  assign qbit  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(DIV_STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg  <= dividend[PROD_W-1];
      work <= mag[MAG_W-1:0];
      rem  <= '0;
      dsr  <= divisor;
    end else if (busy) begin
      rem  <= qbit ? LIM_W'(trial - {1'b0, dsr}) : trial[LIM_W-1:0];
      work <= {work[MAG_W-2:0], qbit};
    end
  end

  always_comb begin
    if (!neg) begin
      quotient = (work > MAG_W'(WMAX64)) ? WMAX64[W-1:0] : work[W-1:0];
    end else begin
      quotient = (work > MAG_W'(-WMIN64)) ? WMIN64[W-1:0] : W'(-work[W-1:0]);
    end
  end

endmodule

>>> src/clamped_pid_controller.sv
// A held output (first sample or non-positive dt) skips the computation;
// every other sample gets a computed output.
// One item at a time: the next item is accepted only once the result has
// entered the output register, later while an earlier result waits.
// The computed path runs the 63-step serial divide by dt; the four
// products share one registered 32x32 multiplier. Reset (synchronous, active
// high) clears gains, limits and controller state.
module clamped_pid_controller (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [cpid_pkg::IDX_W-1:0]       cfg_index,
  input  logic [cpid_pkg::W-1:0]           cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [cpid_pkg::W-1:0]    setpoint,
  input  logic signed [cpid_pkg::W-1:0]    measurement,
  input  logic        [cpid_pkg::W-1:0]    timestamp,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [cpid_pkg::W-1:0]    drive,
  output logic                             held
);
  import cpid_pkg::*;

  state_t state, state_next;

  logic signed [W-1:0]     gain_prop, gain_integral, gain_deriv;
  logic [LIM_W-1:0]        limit_prop, limit_integral, limit_deriv, limit_total;

  logic                    started;
  logic [W-1:0]            prev_time;
  logic signed [W-1:0]     prev_error;
  logic signed [W-1:0]     integral_term;
  logic signed [W-1:0]     last_drive;
  logic                    held_flag;

  logic signed [W-1:0]     err, diff, dt, p_term, t_term, inc, d_term;
  logic signed [W-1:0]     err_in;
  logic [W-1:0]            dt_in;
  logic                    accept, dt_pos;

  logic signed [W-1:0]     mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic                    div_start, div_busy;
  logic signed [W-1:0]     quot;

  cpid_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  cpid_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (dt[LIM_W-1:0]),
    .busy     (div_busy),
    .quotient (quot)
  );

  assign accept = in_valid && in_ready;
  assign err_in = sat_word(ext(setpoint) - ext(measurement));
  assign dt_in  = timestamp - prev_time;
  assign dt_pos = !dt_in[W-1] && (dt_in != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    div_start  = 1'b0;
    mul_a      = err;
    mul_b      = gain_prop;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = (started && dt_pos) ? S_MP : S_OUT;
        end
      end
      S_MP: begin
        state_next = S_MI;
      end
      S_MI: begin
        mul_b      = gain_integral;
        state_next = S_MD;
      end
      S_MD: begin
        mul_a      = diff;
        mul_b      = gain_deriv;
        state_next = S_MT;
      end
      S_MT: begin
        mul_a      = t_term;
        mul_b      = dt;
        div_start  = 1'b1;
        state_next = S_INC;
      end
      S_INC: state_next = S_ACC;
      S_ACC: state_next = S_DIV;
      S_DIV: begin
        if (!div_busy) begin
          state_next = S_SUM;
        end
      end
      S_SUM: state_next = S_OUT;
      S_OUT: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // configuration and controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_prop      <= '0;
      gain_integral  <= '0;
      gain_deriv     <= '0;
      limit_prop     <= '0;
      limit_integral <= '0;
      limit_deriv    <= '0;
      limit_total    <= '0;
      started        <= 1'b0;
      prev_time      <= '0;
      prev_error     <= '0;
      integral_term  <= '0;
      last_drive     <= '0;
      held_flag      <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_GAIN_PROP:      gain_prop      <= cfg_data;
          REG_GAIN_INTEGRAL:  gain_integral  <= cfg_data;
          REG_GAIN_DERIV:     gain_deriv     <= cfg_data;
          REG_LIMIT_PROP:     limit_prop     <= cfg_data[LIM_W-1:0];
          REG_LIMIT_INTEGRAL: limit_integral <= cfg_data[LIM_W-1:0];
          REG_LIMIT_DERIV:    limit_deriv    <= cfg_data[LIM_W-1:0];
          REG_LIMIT_TOTAL:    limit_total    <= cfg_data[LIM_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        started   <= 1'b1;
        prev_time <= timestamp;
        held_flag <= 1'b1;
        if (!started) begin
          prev_error <= err_in;
        end
      end
      if (state == S_ACC) begin
        integral_term <= clamp_sym(ext(sat_word(ext(integral_term) + ext(inc))),
                                   limit_integral);
      end
      if (state == S_SUM) begin
        last_drive <= clamp_sym(ext(p_term) + ext(integral_term) + ext(d_term),
                                limit_total);
        prev_error <= err;
        held_flag  <= 1'b0;
      end
      if (state == S_OUT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      err <= err_in;
      dt  <= dt_in;
    end
    if (state == S_MP) begin
      diff <= sat_word(ext(err) - ext(prev_error));
    end
    if (state == S_MI) begin
      p_term <= clamp_sym(ext(scale_sat(prod)), limit_prop);
    end
    if (state == S_MD) begin
      t_term <= scale_sat(prod);
    end
    if (state == S_INC) begin
      inc <= scale_sat(prod);
    end
    if (state == S_DIV && !div_busy) begin
      d_term <= clamp_sym(ext(quot), limit_deriv);
    end
    if (state == S_OUT && (!out_valid || out_ready)) begin
      drive <= last_drive;
      held  <= held_flag;
    end
  end

endmodule
